@@ src/twsm_pkg.sv @@
// shared types and codes for the two-way sorted merge unit
`timescale 1ns / 1ps

package twsm_pkg;

  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_APPEND_FIRST  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND_SECOND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MERGE         = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } state_t;

endpackage

@@ src/twsm_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module twsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/two_way_sorted_merge_unit.sv @@
// top level of the two-way sorted merge unit
//
// Usage: drive in_command and in_value with start high; the item is taken at
// a rising edge where start is high and busy is low.
// Append commands write in_value to the end of the first or second list;
// busy stays low, so appends can be issued every cycle. An append
// to a full list is dropped and sets a sticky overflow flag.
// A merge command raises busy while its results are picked. One
// shared signed comparator picks the smaller head each cycle, so the results
// come out on consecutive cycles, the first after the state and output
// registers, each marked by out_valid for a single cycle. out_last_of_merge
// marks the final one, out_overflow_seen carries the flag on every result.
// The list reads are registered, and the next read address is chosen in the
// same cycle as the compare, which sets the one-result-per-cycle pace.
// After a merge both fills and the flag are zero; merging two empty lists
// emits nothing and leaves busy low. Command code 3 is ignored.
// The result port cannot be stalled. Synchronous reset empties both lists
// and clears the flag; list contents are not cleared.
`timescale 1ns / 1ps

module two_way_sorted_merge_unit #(
  parameter int LIST_DEPTH  = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [twsm_pkg::CMD_W-1:0]    in_command,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  output logic signed [VALUE_WIDTH-1:0] out_merged_value,
  output logic                          out_last_of_merge,
  output logic                          out_overflow_seen
);

  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(LIST_DEPTH);

  twsm_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0] first_count_r, first_count_nxt;
  logic [CNT_W-1:0] second_count_r, second_count_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic             overflow_r, overflow_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_ovf_r, out_ovf_nxt;
  logic [VALUE_WIDTH-1:0] out_value_r, out_value_nxt;

  logic                   accept;
  logic                   wr_first, wr_second;
  logic [VALUE_WIDTH-1:0] first_rd, second_rd;
  logic                   take_first;
  logic                   is_last;
  logic [SUM_W-1:0]       total;

  assign accept = start && !busy;
  assign busy   = (state_r == twsm_pkg::ST_MERGE);

  assign wr_first  = accept && (in_command == twsm_pkg::CMD_APPEND_FIRST)
                     && (first_count_r != FULL);
  assign wr_second = accept && (in_command == twsm_pkg::CMD_APPEND_SECOND)
                     && (second_count_r != FULL);

  twsm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(LIST_DEPTH)) u_first_ram (
    .clk     (clk),
    .wr_en   (wr_first),
    .wr_addr (first_count_r[IDX_W-1:0]),
    .wr_data (in_value),
    .rd_addr (i_nxt[IDX_W-1:0]),
    .rd_data (first_rd)
  );

  twsm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(LIST_DEPTH)) u_second_ram (
    .clk     (clk),
    .wr_en   (wr_second),
    .wr_addr (second_count_r[IDX_W-1:0]),
    .wr_data (in_value),
    .rd_addr (j_nxt[IDX_W-1:0]),
    .rd_data (second_rd)
  );

  // the shared compare: ram outputs always hold the current heads
  assign take_first = (i_r < first_count_r)
                      && ((j_r >= second_count_r) || ($signed(first_rd) <= $signed(second_rd)));

  assign total   = {1'b0, first_count_r} + {1'b0, second_count_r};
  assign is_last = ({1'b0, i_r} + {1'b0, j_r} + SUM_W'(1)) == total;

  always_comb begin
    state_nxt        = state_r;
    first_count_nxt  = first_count_r;
    second_count_nxt = second_count_r;
    i_nxt            = i_r;
    j_nxt            = j_r;
    overflow_nxt     = overflow_r;
    out_valid_nxt    = 1'b0;
    out_last_nxt     = out_last_r;
    out_ovf_nxt      = out_ovf_r;
    out_value_nxt    = out_value_r;

    unique case (state_r)
      twsm_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_command)
            twsm_pkg::CMD_APPEND_FIRST: begin
              if (first_count_r == FULL) begin
                overflow_nxt = 1'b1;
              end else begin
                first_count_nxt = first_count_r + CNT_W'(1);
              end
            end
            twsm_pkg::CMD_APPEND_SECOND: begin
              if (second_count_r == FULL) begin
                overflow_nxt = 1'b1;
              end else begin
                second_count_nxt = second_count_r + CNT_W'(1);
              end
            end
            twsm_pkg::CMD_MERGE: begin
              if (total == '0) begin
                overflow_nxt = 1'b0;
              end else begin
                state_nxt = twsm_pkg::ST_MERGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      twsm_pkg::ST_MERGE: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = is_last;
        out_ovf_nxt   = overflow_r;
        if (take_first) begin
          out_value_nxt = first_rd;
          i_nxt         = i_r + CNT_W'(1);
        end else begin
          out_value_nxt = second_rd;
          j_nxt         = j_r + CNT_W'(1);
        end
        if (is_last) begin
          state_nxt        = twsm_pkg::ST_IDLE;
          i_nxt            = '0;
          j_nxt            = '0;
          first_count_nxt  = '0;
          second_count_nxt = '0;
          overflow_nxt     = 1'b0;
        end
      end
      default: begin
        state_nxt = twsm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= twsm_pkg::ST_IDLE;
      first_count_r  <= '0;
      second_count_r <= '0;
      i_r            <= '0;
      j_r            <= '0;
      overflow_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      first_count_r  <= first_count_nxt;
      second_count_r <= second_count_nxt;
      i_r            <= i_nxt;
      j_r            <= j_nxt;
      overflow_r     <= overflow_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_merged_value  = out_value_r;
  assign out_last_of_merge = out_last_r;
  assign out_overflow_seen = out_ovf_r;

endmodule

@@ src/twsm_checker.sv @@
// port-level checks for the two-way sorted merge unit, with its bind
`timescale 1ns / 1ps

module twsm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [twsm_pkg::CMD_W-1:0] in_command,
  input logic                       out_valid,
  input logic                       out_last_of_merge,
  input logic                       out_overflow_seen
);

  // a merge run is contiguous until its last item
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_merge |=> out_valid)
    else $error("merge run broken before last item");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_merge |=> !out_valid)
    else $error("item right after last of merge");

  a_flag_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_merge |=> out_overflow_seen == $past(out_overflow_seen))
    else $error("overflow flag changed within one merge");

  a_append_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command != twsm_pkg::CMD_MERGE) |=> !busy && !out_valid)
    else $error("non-merge command caused busy or results");

endmodule

bind two_way_sorted_merge_unit twsm_checker u_twsm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_command        (in_command),
  .out_valid         (out_valid),
  .out_last_of_merge (out_last_of_merge),
  .out_overflow_seen (out_overflow_seen)
);

@@ test/two_way_sorted_merge_unit_tb.sv @@
// self-checking testbench for the two-way sorted merge unit
`timescale 1ns / 1ps

module two_way_sorted_merge_unit_tb;

  localparam int LIST_DEPTH = 32;
  localparam int VW = 32;
  localparam int ITEM_TARGET = 220;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [twsm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic signed [VW-1:0] value;
    logic                 last;
    logic                 ovf;
  } merged_elem_t;

  // tracks both lists and the drop flag, and holds the merge results still owed
  class merge_tracker;
    logic signed [VW-1:0] first_list[$];
    logic signed [VW-1:0] second_list[$];
    bit                   dropped;
    merged_elem_t         expected_merge[$];
    int                   fail_count;

    function void note_item(logic [twsm_pkg::CMD_W-1:0] cmd, logic signed [VW-1:0] value);
      int i;
      int j;
      int total;
      merged_elem_t e;
      unique case (cmd)
        twsm_pkg::CMD_APPEND_FIRST: begin
          if (first_list.size() < LIST_DEPTH) first_list.push_back(value);
          else dropped = 1'b1;
        end
        twsm_pkg::CMD_APPEND_SECOND: begin
          if (second_list.size() < LIST_DEPTH) second_list.push_back(value);
          else dropped = 1'b1;
        end
        twsm_pkg::CMD_MERGE: begin
          i = 0;
          j = 0;
          total = first_list.size() + second_list.size();
          for (int k = 0; k < total; k++) begin
            // ties go to the first list
            if (i < first_list.size() &&
                (j >= second_list.size() || first_list[i] <= second_list[j])) begin
              e.value = first_list[i];
              i++;
            end else begin
              e.value = second_list[j];
              j++;
            end
            e.last = (k == total - 1);
            e.ovf  = dropped;
            expected_merge.push_back(e);
          end
          first_list.delete();
          second_list.delete();
          dropped = 1'b0;
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(logic signed [VW-1:0] value, logic last, logic ovf);
      merged_elem_t e;
      if (expected_merge.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: value %0d last %b ovf %b", value, last, ovf);
      end else begin
        e = expected_merge.pop_front();
        if (value !== e.value || last !== e.last || ovf !== e.ovf) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected value %0d last %b ovf %b, got value %0d last %b ovf %b",
                     e.value, e.last, e.ovf, value, last, ovf);
        end
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [twsm_pkg::CMD_W-1:0]    in_command = '0;
  logic signed [VW-1:0]          in_value = '0;
  logic                          out_valid;
  logic signed [VW-1:0]          out_merged_value;
  logic                          out_last_of_merge;
  logic                          out_overflow_seen;

  merge_tracker tracker;
  int items_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;

  two_way_sorted_merge_unit #(
    .LIST_DEPTH (LIST_DEPTH),
    .VALUE_WIDTH(VW)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_merged_value (out_merged_value),
    .out_last_of_merge(out_last_of_merge),
    .out_overflow_seen(out_overflow_seen)
  );

  always #10 clk = ~clk;

  // results cannot be held off, so every strobe is checked as it comes
  always @(posedge clk) begin
    if (rst_n && out_valid)
      tracker.check_result(out_merged_value, out_last_of_merge, out_overflow_seen);
  end

  // called at a rising edge; returns at the edge where the item was taken or after a gap
  task automatic send_item(input logic [twsm_pkg::CMD_W-1:0] cmd, input logic [VW-1:0] val);
    start      <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    do @(posedge clk); while (busy);
    tracker.note_item(cmd, $signed(val));
    if (cmd != CMD_UNUSED) items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                               : $urandom_range(0, 8);
    end
  endtask

  function automatic int rand_elem(int spread);
    unique case (spread)
      0: return int'($urandom());
      1: return int'($urandom_range(0, 12)) - 6;
      default: begin
        unique case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return -1;
          2: return 0;
          3: return 1;
          default: return 32'sh7fff_ffff;
        endcase
      end
    endcase
  endfunction

  // fill both lists in random interleaving, then merge
  task automatic run_merge_round();
    int first_vals[$];
    int second_vals[$];
    int m;
    int n;
    int mode;
    int spread;
    mode = $urandom_range(0, 15);
    spread = $urandom_range(0, 2);
    if (mode == 0) begin
      m = 0;
      n = 0;
    end else if (mode == 1) begin
      m = $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 4);
      n = $urandom_range(0, 4);
    end else if (mode == 2) begin
      m = $urandom_range(0, 4);
      n = $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 4);
    end else if (mode == 3) begin
      m = LIST_DEPTH;
      n = LIST_DEPTH;
    end else begin
      m = $urandom_range(0, 8);
      n = $urandom_range(0, 8);
    end
    for (int k = 0; k < m; k++) first_vals.push_back(rand_elem(spread));
    for (int k = 0; k < n; k++) second_vals.push_back(rand_elem(spread));
    // now and then leave the lists out of order
    if ($urandom_range(0, 9) != 0) begin
      first_vals.sort();
      second_vals.sort();
    end
    while (first_vals.size() + second_vals.size() > 0) begin
      if ($urandom_range(0, 11) == 0) send_item(CMD_UNUSED, $urandom());
      if (second_vals.size() == 0 || (first_vals.size() != 0 && $urandom_range(0, 1)))
        send_item(twsm_pkg::CMD_APPEND_FIRST, first_vals.pop_front());
      else
        send_item(twsm_pkg::CMD_APPEND_SECOND, second_vals.pop_front());
    end
    send_item(twsm_pkg::CMD_MERGE, $urandom());
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL two_way_sorted_merge_unit");
    $finish;
  end

  initial begin
    tracker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // merge with both lists empty, unused code
    send_item(twsm_pkg::CMD_MERGE, 32'h0000_0000);
    send_item(CMD_UNUSED, 32'hffff_ffff);
    // extremes on both lists, with ties across lists
    send_item(twsm_pkg::CMD_APPEND_FIRST, 32'h8000_0000);
    send_item(twsm_pkg::CMD_APPEND_FIRST, 32'h0000_0000);
    send_item(twsm_pkg::CMD_APPEND_FIRST, 32'h7fff_ffff);
    send_item(twsm_pkg::CMD_APPEND_SECOND, 32'h8000_0000);
    send_item(twsm_pkg::CMD_APPEND_SECOND, 32'hffff_ffff);
    send_item(twsm_pkg::CMD_APPEND_SECOND, 32'h7fff_ffff);
    send_item(twsm_pkg::CMD_MERGE, 32'hffff_ffff);
    send_item(CMD_UNUSED, 32'h0000_0000);
    // one list empty, then the other
    send_item(twsm_pkg::CMD_APPEND_SECOND, 32'd7);
    send_item(twsm_pkg::CMD_MERGE, 32'h0000_0000);
    send_item(twsm_pkg::CMD_APPEND_FIRST, -32'sd5);
    send_item(twsm_pkg::CMD_MERGE, 32'h0000_0000);
    // lists out of order
    send_item(twsm_pkg::CMD_APPEND_FIRST, 32'd5);
    send_item(twsm_pkg::CMD_APPEND_FIRST, -32'sd3);
    send_item(twsm_pkg::CMD_APPEND_SECOND, 32'd0);
    send_item(twsm_pkg::CMD_APPEND_SECOND, -32'sd10);
    send_item(twsm_pkg::CMD_MERGE, 32'h0000_0000);
    send_item(twsm_pkg::CMD_MERGE, 32'h5555_5555);

    while (items_sent < ITEM_TARGET) run_merge_round();
    start <= 1'b0;

    while (tracker.expected_merge.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.fail_count == 0) begin
      $display("PASS two_way_sorted_merge_unit");
    end else begin
      $display("FAIL two_way_sorted_merge_unit");
    end
    $finish;
  end

endmodule
